// ===== rtl/rfdf_pkg.sv =====
// shared types and constants for the radio frame deframer and address filter
package rfdf_pkg;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 10;
  localparam int LEN_W  = 7;
  localparam int PLEN_W = 6;

  // header bytes after the length byte
  localparam logic [LEN_W-1:0] HDR_BYTES = 7'd3;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_EMPTY = 1'b1;

  // one result word
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [ADDR_W-1:0] sender_address;
    logic [PLEN_W-1:0] body_count;
    logic              last;
  } rfdf_word_t;

endpackage

// ===== rtl/rfdf_ifs.sv =====
// handshake channels: received bytes, result words and the address register write

interface rfdf_byte_if import rfdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] fifo_byte;

  modport source (output valid, output fifo_byte, input ready);
  modport sink   (input valid, input fifo_byte, output ready);
endinterface

interface rfdf_res_if import rfdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [ADDR_W-1:0] sender_address;
  logic [PLEN_W-1:0] body_count;
  logic              last;

  modport source (output valid, output kind, output payload_byte, output sender_address,
                  output body_count, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input sender_address,
                  input body_count, input last, output ready);
endinterface

interface rfdf_cfg_if import rfdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] station_addr;

  modport source (output valid, output station_addr, input ready);
  modport sink   (input valid, input station_addr, output ready);
endinterface

// ===== rtl/rfdf_deframer.sv =====
// frame parser state machine with address filter and own address register
module rfdf_deframer import rfdf_pkg::*; #(
  parameter int MAX_FRAME_LEN = 66
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] fifo_byte,
  input  logic              cfg_wr,
  input  logic [ADDR_W-1:0] cfg_station_addr,
  output logic              emit,
  output rfdf_word_t        word
);

  localparam logic [2:0] PH_LEN  = 3'd0;
  localparam logic [2:0] PH_TGT  = 3'd1;
  localparam logic [2:0] PH_SND  = 3'd2;
  localparam logic [2:0] PH_CTL  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_FRAME_LEN);

  logic [2:0]        phase, phase_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [BYTE_W-1:0] target_low, target_low_next;
  logic [ADDR_W-1:0] sender_addr, sender_addr_next;
  logic [ADDR_W-1:0] station_addr;

  logic [LEN_W-1:0]  pay_cnt;
  logic [PLEN_W-1:0] pay_sat;
  logic [ADDR_W-1:0] tgt_addr;
  logic              rem_le1;

  // payload count of the current frame, and its saturated report value
  assign pay_cnt  = (frame_length >= HDR_BYTES) ? (frame_length - HDR_BYTES) : '0;
  assign pay_sat  = pay_cnt[LEN_W-1] ? {PLEN_W{1'b1}} : pay_cnt[PLEN_W-1:0];
  assign tgt_addr = {fifo_byte[3:2], target_low};
  assign rem_le1  = (remaining <= LEN_W'(1));

  // next state and result for one byte
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    remaining_next    = remaining;
    target_low_next   = target_low;
    sender_addr_next  = sender_addr;
    emit              = 1'b0;
    word.kind           = KIND_DATA;
    word.payload_byte   = '0;
    word.last           = 1'b0;
    if (take) begin
      case (phase)
        PH_TGT: begin
          target_low_next = fifo_byte;
          phase_next      = PH_SND;
        end
        PH_SND: begin
          sender_addr_next = {2'b00, fifo_byte};
          phase_next       = PH_CTL;
        end
        PH_CTL: begin
          sender_addr_next = {fifo_byte[1:0], sender_addr[BYTE_W-1:0]};
          remaining_next   = pay_cnt;
          if (tgt_addr != station_addr) begin
            phase_next = (pay_cnt == '0) ? PH_LEN : PH_SKIP;
          end else if (pay_cnt == '0) begin
            phase_next = PH_LEN;
            emit       = 1'b1;
            word.kind  = KIND_EMPTY;
            word.last  = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          remaining_next    = rem_le1 ? '0 : remaining - LEN_W'(1);
          if (rem_le1) begin
            phase_next = PH_LEN;
          end
          emit              = 1'b1;
          word.payload_byte = fifo_byte;
          word.last         = rem_le1;
        end
        PH_SKIP: begin
          remaining_next = rem_le1 ? '0 : remaining - LEN_W'(1);
          if (rem_le1) begin
            phase_next = PH_LEN;
          end
        end
        default: begin
          frame_length_next = (fifo_byte > MaxLen) ? MaxLen[LEN_W-1:0] : fifo_byte[LEN_W-1:0];
          phase_next        = PH_TGT;
        end
      endcase
    end
    word.sender_address = sender_addr_next;
    word.body_count     = pay_sat;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      frame_length <= '0;
      remaining    <= '0;
      target_low   <= '0;
      sender_addr  <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      remaining    <= remaining_next;
      target_low   <= target_low_next;
      sender_addr  <= sender_addr_next;
    end
  end

  // own address register
  always_ff @(posedge clk) begin
    if (rst) begin
      station_addr <= '0;
    end else if (cfg_wr) begin
      station_addr <= cfg_station_addr;
    end
  end

`ifndef SYNTHESIS
  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    emit |-> (phase == PH_CTL || phase == PH_DATA))
    else $error("result word outside control or data phase");
  a_data_rem: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA || phase == PH_SKIP) |-> (remaining != '0))
    else $error("payload phase with no bytes remaining");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (emit && word.last) |=> (phase == PH_LEN))
    else $error("frame did not end after last word");
`endif

endmodule

// ===== rtl/rfdf_out_reg.sv =====
// result register between the parser and the result channel
module rfdf_out_reg import rfdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rfdf_word_t load_word,
  input  logic       out_ready,
  output logic       out_valid,
  output rfdf_word_t out_word,
  output logic       space
);

  logic       valid_q;
  rfdf_word_t word_q;

  // room for a new word when empty or when the held word leaves this cycle
  assign space     = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign out_word  = word_q;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready) begin
      valid_q <= 1'b0;
    end
  end

  // word payload
  always_ff @(posedge clk) begin
    if (load) begin
      word_q <= load_word;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!valid_q || out_ready))
    else $error("result word overwritten before it was taken");
`endif

endmodule

// ===== rtl/radio_frame_deframer_filter.sv =====
// top level: received byte deframer with 10-bit target address filter
// latency: a result word is valid the cycle after the byte that causes it is accepted
// throughput: one byte per cycle, limited only by the single result register draining
// a byte is taken while the result register is empty or its word is taken the same cycle
// reset (rst, synchronous): parser expects a length byte, own address 0, no result held
// the address register write channel is always ready
module radio_frame_deframer_filter import rfdf_pkg::*; #(
  parameter int MAX_FRAME_LEN = 66
) (
  input  logic        clk,
  input  logic        rst,
  rfdf_byte_if.sink   rx,
  rfdf_res_if.source  res,
  rfdf_cfg_if.sink    cfg
);

  logic       take;
  logic       emit;
  logic       space;
  rfdf_word_t word;
  rfdf_word_t res_word;

  // byte handshake
  assign rx.ready  = space;
  assign take      = rx.valid && space;
  assign cfg.ready = 1'b1;

  rfdf_deframer #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_deframer (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .fifo_byte        (rx.fifo_byte),
    .cfg_wr           (cfg.valid),
    .cfg_station_addr (cfg.station_addr),
    .emit             (emit),
    .word             (word)
  );

  rfdf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_word (word),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .out_word  (res_word),
    .space     (space)
  );

  // result fields
  assign res.kind           = res_word.kind;
  assign res.payload_byte   = res_word.payload_byte;
  assign res.sender_address = res_word.sender_address;
  assign res.body_count     = res_word.body_count;
  assign res.last           = res_word.last;

endmodule

// ===== tb/sv/radio_frame_deframer_filter_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the radio frame deframer and address filter
module radio_frame_deframer_filter_tb;
  import rfdf_pkg::*;

  localparam int FRAME_MAX   = 66;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_BYTES = 160;

  typedef enum logic [2:0] {ST_LEN, ST_TGT, ST_SND, ST_CTL, ST_DATA, ST_SKIP} parse_st_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rfdf_byte_if rx_ch ();
  rfdf_res_if  res_ch ();
  rfdf_cfg_if  cfg_ch ();

  radio_frame_deframer_filter #(.MAX_FRAME_LEN(FRAME_MAX)) DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // 4 ns clock
  always #2 clk = ~clk;

  // deframer state as the testbench tracks it
  parse_st_t         ph;
  logic [LEN_W-1:0]  flen;
  logic [LEN_W-1:0]  left;
  logic [BYTE_W-1:0] tgt_lo;
  logic [ADDR_W-1:0] snd;
  logic [ADDR_W-1:0] own_addr;

  rfdf_word_t        exp_words[$];
  logic [BYTE_W-1:0] byte_q[$];

  int queued_bytes  = 0;
  int taken_bytes   = 0;
  int words_checked = 0;
  int empty_words   = 0;
  int mismatches    = 0;
  int in_stalls     = 0;
  int cycles        = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int tx_gap        = 0;
  int rx_gap        = 0;
  int hold_cnt      = 0;
  bit rx_taken      = 1'b0;
  bit idle_on       = 1'b1;

  // payload byte count of the frame being parsed
  function automatic logic [LEN_W-1:0] body_len();
    return (flen >= HDR_BYTES) ? flen - HDR_BYTES : '0;
  endfunction

  function automatic void push_word(logic kind, logic [BYTE_W-1:0] data, logic lst);
    rfdf_word_t       w;
    logic [LEN_W-1:0] n;
    n                = body_len();
    w.kind           = kind;
    w.payload_byte   = data;
    w.sender_address = snd;
    w.body_count     = (n > 63) ? '1 : n[PLEN_W-1:0];
    w.last           = lst;
    exp_words.push_back(w);
  endfunction

  // advance the frame parser by one received byte
  function automatic void deframe_byte(logic [BYTE_W-1:0] b);
    logic [ADDR_W-1:0] tgt;
    logic [LEN_W-1:0]  n;
    logic              lst;
    case (ph)
      ST_TGT: begin
        tgt_lo = b;
        ph     = ST_SND;
      end
      ST_SND: begin
        snd = {2'b00, b};
        ph  = ST_CTL;
      end
      ST_CTL: begin
        tgt      = {b[3:2], tgt_lo};
        n        = body_len();
        snd[9:8] = b[1:0];
        left     = n;
        if (tgt != own_addr) begin
          ph = (n == 0) ? ST_LEN : ST_SKIP;
        end else if (n == 0) begin
          ph = ST_LEN;
          push_word(KIND_EMPTY, '0, 1'b1);
        end else begin
          ph = ST_DATA;
        end
      end
      ST_DATA: begin
        lst  = (left <= 1);
        left = lst ? '0 : left - 1'b1;
        if (lst) ph = ST_LEN;
        push_word(KIND_DATA, b, lst);
      end
      ST_SKIP: begin
        left = (left <= 1) ? '0 : left - 1'b1;
        if (left == 0) ph = ST_LEN;
      end
      default: begin
        flen = LEN_W'((b > FRAME_MAX) ? FRAME_MAX : int'(b));
        ph   = ST_TGT;
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // sample both channels and the register write at the rising edge
  always @(posedge clk) begin : watch
    rfdf_word_t want;
    rx_taken = rx_ch.valid && rx_ch.ready && !rst;
    if (rst) begin
      ph       = ST_LEN;
      flen     = '0;
      left     = '0;
      tgt_lo   = '0;
      snd      = '0;
      own_addr = '0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (exp_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, actual byte %0d sender %0d", $time,
                   res_ch.payload_byte, res_ch.sender_address);
        end else begin
          want = exp_words.pop_front();
          words_checked++;
          if (want.kind == KIND_EMPTY) empty_words++;
          check_field("kind", want.kind, res_ch.kind);
          check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
          check_field("sender_address", want.sender_address, res_ch.sender_address);
          check_field("body_count", want.body_count, res_ch.body_count);
          check_field("last", want.last, res_ch.last);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) own_addr = cfg_ch.station_addr;
      if (rx_taken) begin
        taken_bytes++;
        deframe_byte(rx_ch.fifo_byte);
      end
      if (rx_ch.valid && !rx_ch.ready) in_stalls++;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: cycle limit reached, %0d words still expected", $time, exp_words.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // byte driver with random gaps
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        rx_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        tx_gap = $urandom_range(0, 9);
        rx_ch.valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        rx_ch.valid     <= 1'b1;
        rx_ch.fifo_byte <= byte_q.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus the long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      res_ch.ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_cnt = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      rx_gap = $urandom_range(0, 9);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic put_byte(logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    queued_bytes++;
  endtask

  // length, target low, sender low, control
  task automatic put_header(logic [BYTE_W-1:0] len, logic [ADDR_W-1:0] tgt,
                            logic [ADDR_W-1:0] src);
    put_byte(len);
    put_byte(tgt[7:0]);
    put_byte(src[7:0]);
    put_byte({4'($urandom_range(0, 15)), tgt[9:8], src[9:8]});
  endtask

  task automatic put_frame(logic [BYTE_W-1:0] len, logic [ADDR_W-1:0] tgt,
                           logic [ADDR_W-1:0] src);
    int c;
    c = (len > FRAME_MAX) ? FRAME_MAX : int'(len);
    put_header(len, tgt, src);
    repeat ((c >= HDR_BYTES) ? c - HDR_BYTES : 0) put_byte($urandom_range(0, 255));
  endtask

  // sender stops until every byte is taken and every word has come back
  task automatic wait_idle();
    while (taken_bytes != queued_bytes || exp_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_own(logic [ADDR_W-1:0] addr);
    wait_idle();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.station_addr <= addr;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one address setting with random frames, ending in a few stray bytes
  task automatic random_phase(logic [ADDR_W-1:0] addr, bit squeeze);
    int                start;
    int                r;
    int                k;
    int                len;
    logic [ADDR_W-1:0] tgt;
    write_own(addr);
    // close the frame that the stray bytes of the last phase opened
    case (ph)
      ST_TGT:           k = 3 + body_len();
      ST_SND:           k = 2 + body_len();
      ST_CTL:           k = 1 + body_len();
      ST_DATA, ST_SKIP: k = left;
      default:          k = 0;
    endcase
    repeat (k) put_byte($urandom_range(0, 255));
    start = queued_bytes;
    if (squeeze) hold_asked++;
    while (queued_bytes - start < PHASE_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 55) len = $urandom_range(0, 12);
      else if (r < 88) len = $urandom_range(13, FRAME_MAX);
      else len = $urandom_range(FRAME_MAX + 1, 255);
      case ($urandom_range(0, 7))
        5:       tgt = addr ^ 10'h100;
        6:       tgt = addr ^ 10'h200;
        7:       tgt = ADDR_W'($urandom_range(0, 1023));
        default: tgt = addr;
      endcase
      put_frame(len, tgt, ADDR_W'($urandom_range(0, 1023)));
    end
    repeat ($urandom_range(0, 6)) put_byte($urandom_range(0, 255));
  endtask

  initial begin
    rx_ch.valid         = 1'b0;
    rx_ch.fifo_byte     = '0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.station_addr = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at the reset address
    put_header(8'd3, 10'h000, 10'h3FF);
    put_header(8'd0, 10'h000, 10'h155);
    put_header(8'd5, 10'h000, 10'h001);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_header(8'd4, 10'h300, 10'h0F0);
    put_byte(8'h5A);
    put_header(8'd1, 10'h100, 10'h000);

    // oversize length clamps to the largest frame
    write_own(10'h3FF);
    put_frame(8'hFF, 10'h3FF, 10'h3FF);

    // address changes between sender byte and control byte
    put_byte(8'd6);
    put_byte(8'hA5);
    put_byte(8'h3C);
    write_own(10'h2A5);
    put_byte({4'h9, 2'b10, 2'b01});
    repeat (3) put_byte($urandom_range(0, 255));

    random_phase(10'h000, 1'b0);
    random_phase(10'h3FF, 1'b1);
    random_phase(ADDR_W'($urandom_range(0, 1023)), 1'b0);
    random_phase(10'h2AA, 1'b0);
    random_phase(ADDR_W'($urandom_range(0, 1023)), 1'b0);
    wait_idle();
    idle_on = 1'b0;
    random_phase(ADDR_W'($urandom_range(0, 1023)), 1'b0);
    wait_idle();
    repeat (10) @(negedge clk);

    $display("%0d bytes sent, %0d result words checked, %0d of them empty-frame words",
             taken_bytes, words_checked, empty_words);
    $display("own address set to both extremes and random values, input stalled %0d cycles",
             in_stalls);
    if (mismatches == 0 && exp_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
